// File: rtl/core/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master register transfer package
// Shared types, constants and state codes for the transfer sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned TickW  = 3;
  localparam int unsigned BitW   = 4;
  localparam int unsigned ApbW   = 32;
  localparam int unsigned PaddrW = 3;

  localparam logic [ByteW-1:0] AckTimeoutReset = 8'd250;
  localparam logic [ByteW-1:0] MsbMask         = 8'h80;

  // Request codes
  localparam logic [ReqW-1:0] ReqTick  = 2'd0;
  localparam logic [ReqW-1:0] ReqRead  = 2'd1;
  localparam logic [ReqW-1:0] ReqWrite = 2'd2;

  // Register index decoded from paddr[2]
  localparam logic RegAckTimeout = 1'b0;

  typedef enum logic [14:0] {
    PhIdle      = 15'b000000000000001,
    PhStart1    = 15'b000000000000010,
    PhSendDev   = 15'b000000000000100,
    PhAckDev    = 15'b000000000001000,
    PhSendReg   = 15'b000000000010000,
    PhAckReg    = 15'b000000000100000,
    PhStart2    = 15'b000000001000000,
    PhSendDevr  = 15'b000000010000000,
    PhAckDevr   = 15'b000000100000000,
    PhSendData  = 15'b000001000000000,
    PhAckData   = 15'b000010000000000,
    PhReadBits  = 15'b000100000000000,
    PhMasterAck = 15'b001000000000000,
    PhStop      = 15'b010000000000000,
    PhStopFail  = 15'b100000000000000
  } phase_e;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [ByteW-1:0] dev_addr;
    logic [ByteW-1:0] reg_addr;
    logic [ByteW-1:0] byte_count;
    logic [ByteW-1:0] wr_byte;
    logic             sda_in;
  } req_t;

  typedef struct packed {
    logic             scl_level;
    logic             sda_level;
    logic             sda_drive_en;
    logic [ByteW-1:0] rd_byte;
    logic             rd_valid;
    logic             wr_taken;
    logic             busy_res;
    logic             done_res;
    logic             failed;
  } res_t;

endpackage

// File: rtl/core/i2cm_req_if.sv
// ----------------------------------------------------------------------------
// I2C master request channel
// Valid/ready channel carrying one bus tick and an optional transfer command.
// ----------------------------------------------------------------------------
interface i2cm_req_if;
  logic                        valid;
  logic                        ready;
  logic [i2cm_pkg::ReqW-1:0]   req_type;
  logic [i2cm_pkg::ByteW-1:0]  dev_addr;
  logic [i2cm_pkg::ByteW-1:0]  reg_addr;
  logic [i2cm_pkg::ByteW-1:0]  byte_count;
  logic [i2cm_pkg::ByteW-1:0]  wr_byte;
  logic                        sda_in;

  modport source (
    output valid, req_type, dev_addr, reg_addr, byte_count, wr_byte, sda_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, dev_addr, reg_addr, byte_count, wr_byte, sda_in,
    output ready
  );
endinterface

// File: rtl/core/i2cm_res_if.sv
// ----------------------------------------------------------------------------
// I2C master result channel
// Valid/ready channel carrying the bus levels and status for one tick.
// ----------------------------------------------------------------------------
interface i2cm_res_if;
  logic                        valid;
  logic                        ready;
  logic                        scl_level;
  logic                        sda_level;
  logic                        sda_drive_en;
  logic [i2cm_pkg::ByteW-1:0]  rd_byte;
  logic                        rd_valid;
  logic                        wr_taken;
  logic                        busy_res;
  logic                        done_res;
  logic                        failed;

  modport source (
    output valid, scl_level, sda_level, sda_drive_en, rd_byte, rd_valid,
           wr_taken, busy_res, done_res, failed,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, sda_drive_en, rd_byte, rd_valid,
           wr_taken, busy_res, done_res, failed,
    output ready
  );
endinterface

// File: rtl/core/i2c_master_register_transfer.sv
// Path: an accepted request is held in the input register, then the sequencer
//   step writes its result into the result register.
// Throughput: one request per cycle while res_o is not stalled; the
//   sequencer steps one bus tick per request in the single-step phase logic.
// Reset: rst_ni clears both stage valids, the sequencer (idle phase, counters
//   zero) and sets ack_timeout to 250. No clearing pass is needed.
// ----------------------------------------------------------------------------
// I2C master register transfer
// Tick-driven I2C master running register writes and register reads with
// start, repeated start, ACK polling with timeout, and stop.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  i2cm_req_if.sink                      req_i,
  i2cm_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cm_pkg::PaddrW-1:0]   paddr,
  input  logic [i2cm_pkg::ApbW-1:0]     pwdata,
  output logic [i2cm_pkg::ApbW-1:0]     prdata,
  output logic                          pready
);

  localparam int unsigned ByteW = i2cm_pkg::ByteW;
  localparam int unsigned TickW = i2cm_pkg::TickW;
  localparam int unsigned BitW  = i2cm_pkg::BitW;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [ByteW-1:0] ack_timeout_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == i2cm_pkg::RegAckTimeout);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= i2cm_pkg::AckTimeoutReset;
    end else if (cfg_wr) begin
      ack_timeout_q <= pwdata[ByteW-1:0];
    end
  end

  assign prdata = (paddr[2] == i2cm_pkg::RegAckTimeout) ?
                  {{(i2cm_pkg::ApbW-ByteW){1'b0}}, ack_timeout_q} : '0;

  // --------------------------------------------------------------------------
  // Pipeline handshake: input register feeds the sequencer step, which
  // loads the result register. Advance whenever the result slot is free.
  // --------------------------------------------------------------------------
  i2cm_pkg::req_t in_q;
  logic           in_valid_q;
  i2cm_pkg::res_t out_q;
  logic           out_valid_q;
  logic           advance;
  logic           step;

  assign advance     = !out_valid_q || res_o.ready;
  assign step        = advance && in_valid_q;
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_q.req_type   <= req_i.req_type;
      in_q.dev_addr   <= req_i.dev_addr;
      in_q.reg_addr   <= req_i.reg_addr;
      in_q.byte_count <= req_i.byte_count;
      in_q.wr_byte    <= req_i.wr_byte;
      in_q.sda_in     <= req_i.sda_in;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  i2cm_pkg::phase_e phase_q, phase_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [BitW-1:0]  bit_q, bit_d;
  logic [ByteW-1:0] bytes_done_q, bytes_done_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic [ByteW-1:0] ack_wait_q, ack_wait_d;
  logic [ByteW-1:0] dev_q, dev_d;
  logic [ByteW-1:0] reg_q, reg_d;
  logic [ByteW-1:0] count_q, count_d;
  logic             is_read_q, is_read_d;
  i2cm_pkg::res_t   res_d;
  logic [ByteW:0]   next_done;
  logic             last_byte;

  // One bus tick of the transfer sequencer.
  always_comb begin
    phase_d      = phase_q;
    tick_d       = tick_q;
    bit_d        = bit_q;
    bytes_done_d = bytes_done_q;
    shift_d      = shift_q;
    ack_wait_d   = ack_wait_q;
    dev_d        = dev_q;
    reg_d        = reg_q;
    count_d      = count_q;
    is_read_d    = is_read_q;

    res_d.scl_level    = 1'b1;
    res_d.sda_level    = 1'b1;
    res_d.sda_drive_en = 1'b1;
    res_d.rd_byte      = '0;
    res_d.rd_valid     = 1'b0;
    res_d.wr_taken     = 1'b0;
    res_d.busy_res     = 1'b1;
    res_d.done_res     = 1'b0;
    res_d.failed       = 1'b0;

    next_done = {1'b0, bytes_done_q} + 1'b1;
    last_byte = next_done >= {1'b0, count_q};

    // A command in idle starts the transfer on this very tick.
    if (phase_q == i2cm_pkg::PhIdle &&
        (in_q.req_type == i2cm_pkg::ReqRead || in_q.req_type == i2cm_pkg::ReqWrite)) begin
      dev_d        = in_q.dev_addr;
      reg_d        = in_q.reg_addr;
      count_d      = in_q.byte_count;
      is_read_d    = (in_q.req_type == i2cm_pkg::ReqRead);
      bytes_done_d = '0;
      shift_d      = '0;
      phase_d      = i2cm_pkg::PhStart1;
      tick_d       = '0;
      bit_d        = '0;
      ack_wait_d   = '0;
    end

    case (phase_d)
      i2cm_pkg::PhStart1, i2cm_pkg::PhStart2: begin
        res_d.sda_level = (tick_d < TickW'(4));
        if (tick_d == TickW'(7)) begin
          shift_d = (phase_d == i2cm_pkg::PhStart1) ? dev_d : dev_d + 1'b1;
          phase_d = (phase_d == i2cm_pkg::PhStart1) ? i2cm_pkg::PhSendDev
                                                    : i2cm_pkg::PhSendDevr;
          tick_d  = '0;
          bit_d   = '0;
        end else begin
          tick_d = tick_d + 1'b1;
        end
      end

      i2cm_pkg::PhSendDev, i2cm_pkg::PhSendReg,
      i2cm_pkg::PhSendDevr, i2cm_pkg::PhSendData: begin
        // Fetch the next data byte on the first tick of its first bit.
        if (phase_d == i2cm_pkg::PhSendData && bit_d == '0 && tick_d == '0) begin
          shift_d        = in_q.wr_byte;
          res_d.wr_taken = 1'b1;
        end
        res_d.sda_level = |(shift_d & i2cm_pkg::MsbMask);
        res_d.scl_level = (tick_d == TickW'(1));
        if (tick_d >= TickW'(2)) begin
          tick_d  = '0;
          shift_d = {shift_d[ByteW-2:0], 1'b0};
          bit_d   = bit_d + 1'b1;
          if (bit_d >= BitW'(8)) begin
            case (phase_d)
              i2cm_pkg::PhSendDev:  phase_d = i2cm_pkg::PhAckDev;
              i2cm_pkg::PhSendReg:  phase_d = i2cm_pkg::PhAckReg;
              i2cm_pkg::PhSendDevr: phase_d = i2cm_pkg::PhAckDevr;
              default:              phase_d = i2cm_pkg::PhAckData;
            endcase
            tick_d     = '0;
            bit_d      = '0;
            ack_wait_d = '0;
          end
        end else begin
          tick_d = tick_d + 1'b1;
        end
      end

      i2cm_pkg::PhAckDev, i2cm_pkg::PhAckReg,
      i2cm_pkg::PhAckDevr, i2cm_pkg::PhAckData: begin
        res_d.sda_drive_en = 1'b0;
        if (tick_d == '0) begin
          res_d.scl_level = 1'b0;
          tick_d          = TickW'(1);
        end else if (tick_d == TickW'(1)) begin
          tick_d = TickW'(2);
        end else if (!in_q.sda_in) begin
          // Slave acknowledged: move on to the next part of the transfer.
          tick_d = '0;
          bit_d  = '0;
          case (phase_d)
            i2cm_pkg::PhAckDev: begin
              shift_d = reg_d;
              phase_d = i2cm_pkg::PhSendReg;
            end
            i2cm_pkg::PhAckReg: begin
              bytes_done_d = '0;
              ack_wait_d   = '0;
              if (is_read_d) begin
                phase_d = i2cm_pkg::PhStart2;
              end else begin
                phase_d = (count_d != '0) ? i2cm_pkg::PhSendData : i2cm_pkg::PhStop;
              end
            end
            i2cm_pkg::PhAckDevr: begin
              bytes_done_d = '0;
              shift_d      = '0;
              ack_wait_d   = '0;
              phase_d      = (count_d != '0) ? i2cm_pkg::PhReadBits : i2cm_pkg::PhStop;
            end
            default: begin
              bytes_done_d = next_done[ByteW-1:0];
              ack_wait_d   = '0;
              phase_d      = (next_done[ByteW-1:0] < count_d) ? i2cm_pkg::PhSendData
                                                              : i2cm_pkg::PhStop;
            end
          endcase
        end else if (ack_wait_d >= ack_timeout_q) begin
          phase_d    = i2cm_pkg::PhStopFail;
          tick_d     = '0;
          bit_d      = '0;
          ack_wait_d = '0;
        end else begin
          ack_wait_d = ack_wait_d + 1'b1;
        end
      end

      i2cm_pkg::PhReadBits: begin
        res_d.sda_drive_en = 1'b0;
        if (tick_d == '0) begin
          res_d.scl_level = 1'b0;
          tick_d          = TickW'(1);
        end else begin
          shift_d = {shift_d[ByteW-2:0], in_q.sda_in};
          tick_d  = '0;
          bit_d   = bit_d + 1'b1;
          if (bit_d >= BitW'(8)) begin
            phase_d = i2cm_pkg::PhMasterAck;
            bit_d   = '0;
          end
        end
      end

      i2cm_pkg::PhMasterAck: begin
        // ACK holds SCL high two ticks, NACK on the last byte only one.
        res_d.sda_level = last_byte;
        res_d.scl_level = (tick_d != '0);
        if (tick_d >= (last_byte ? TickW'(1) : TickW'(2))) begin
          res_d.rd_byte  = shift_d;
          res_d.rd_valid = 1'b1;
          bytes_done_d   = next_done[ByteW-1:0];
          shift_d        = '0;
          phase_d        = (next_done[ByteW-1:0] >= count_d) ? i2cm_pkg::PhStop
                                                             : i2cm_pkg::PhReadBits;
          tick_d         = '0;
          bit_d          = '0;
          ack_wait_d     = '0;
        end else begin
          tick_d = tick_d + 1'b1;
        end
      end

      i2cm_pkg::PhStop, i2cm_pkg::PhStopFail: begin
        res_d.scl_level = (tick_d >= TickW'(4));
        res_d.sda_level = (tick_d >= TickW'(4));
        if (tick_d == TickW'(7)) begin
          res_d.done_res = 1'b1;
          res_d.failed   = (phase_d == i2cm_pkg::PhStopFail);
          phase_d        = i2cm_pkg::PhIdle;
          tick_d         = '0;
          bit_d          = '0;
          ack_wait_d     = '0;
          bytes_done_d   = '0;
        end else begin
          tick_d = tick_d + 1'b1;
        end
      end

      default: begin
        phase_d        = i2cm_pkg::PhIdle;
        tick_d         = '0;
        bit_d          = '0;
        res_d.busy_res = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= i2cm_pkg::PhIdle;
      tick_q       <= '0;
      bit_q        <= '0;
      bytes_done_q <= '0;
      shift_q      <= '0;
      ack_wait_q   <= '0;
      dev_q        <= '0;
      reg_q        <= '0;
      count_q      <= '0;
      is_read_q    <= 1'b0;
    end else if (step) begin
      phase_q      <= phase_d;
      tick_q       <= tick_d;
      bit_q        <= bit_d;
      bytes_done_q <= bytes_done_d;
      shift_q      <= shift_d;
      ack_wait_q   <= ack_wait_d;
      dev_q        <= dev_d;
      reg_q        <= reg_d;
      count_q      <= count_d;
      is_read_q    <= is_read_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.scl_level    = out_q.scl_level;
  assign res_o.sda_level    = out_q.sda_level;
  assign res_o.sda_drive_en = out_q.sda_drive_en;
  assign res_o.rd_byte      = out_q.rd_byte;
  assign res_o.rd_valid     = out_q.rd_valid;
  assign res_o.wr_taken     = out_q.wr_taken;
  assign res_o.busy_res     = out_q.busy_res;
  assign res_o.done_res     = out_q.done_res;
  assign res_o.failed       = out_q.failed;

endmodule

// File: tb/i2c_master_register_transfer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master register transfer testbench
// Sends bus ticks with register read and write commands into the sequencer.
// A local model of the sequencer predicts the bus levels and status of every
// tick, and each returned result is compared with its prediction. SDA samples
// are chosen from the predicted state, so slaves ACK, refuse or stay silent
// on purpose. Both channels idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer_test;
  import i2cm_pkg::*;

  // Request code with no meaning of its own: the sequencer treats it as a tick.
  localparam logic [ReqW-1:0]   ReqIgnored     = 2'd3;
  localparam logic [PaddrW-1:0] AckTimeoutAddr = {RegAckTimeout, 2'b00};
  localparam int unsigned       CycleLimit     = 400_000;
  localparam int unsigned       PrintLimit     = 200;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [ApbW-1:0]   pwdata;
  logic [ApbW-1:0]   prdata;
  logic              pready;

  i2cm_req_if req_if ();
  i2cm_res_if res_if ();

  i2c_master_register_transfer u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // Sequencer model state: mirrors the block after every accepted request.
  // --------------------------------------------------------------------------
  phase_e           seq_phase;
  logic [TickW-1:0] tick_cnt;
  logic [BitW-1:0]  bit_cnt;
  logic [ByteW-1:0] bytes_moved;
  logic [ByteW-1:0] shift_q;
  logic [ByteW-1:0] poll_cnt;
  logic [ByteW-1:0] dev_q;
  logic [ByteW-1:0] reg_q;
  logic [ByteW-1:0] count_q;
  logic             read_mode;
  logic [ByteW-1:0] ack_limit;

  // Predicted results, oldest first.
  res_t tick_levels_q[$];

  // Traffic shaping knobs, changed by the test tasks.
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned ack_pct;
  phase_e      refused_ack;

  int unsigned items_sent;
  int unsigned err_cnt;
  int unsigned cycle_cnt;

  // --------------------------------------------------------------------------
  // Model helpers
  // --------------------------------------------------------------------------
  function automatic void go_plain(input phase_e nxt);
    seq_phase = nxt;
    tick_cnt  = '0;
    bit_cnt   = '0;
    poll_cnt  = '0;
  endfunction

  // Load a byte to shift out; the ACK poll counter is left alone here.
  function automatic void go_send(input phase_e nxt, input logic [ByteW-1:0] value);
    seq_phase = nxt;
    shift_q   = value;
    tick_cnt  = '0;
    bit_cnt   = '0;
  endfunction

  // Advance the model by one bus tick and return the levels it drives.
  function automatic res_t predict_bus_tick(input req_t rq);
    res_t   r;
    phase_e nxt;
    logic   last_byte;
    r              = '0;
    r.scl_level    = 1'b1;
    r.sda_level    = 1'b1;
    r.sda_drive_en = 1'b1;
    r.busy_res     = 1'b1;
    nxt            = PhIdle;

    // A command while idle starts the transfer on this very tick.
    if (seq_phase == PhIdle && (rq.req_type == ReqRead || rq.req_type == ReqWrite)) begin
      dev_q       = rq.dev_addr;
      reg_q       = rq.reg_addr;
      count_q     = rq.byte_count;
      read_mode   = (rq.req_type == ReqRead);
      bytes_moved = '0;
      shift_q     = '0;
      go_plain(PhStart1);
    end

    case (seq_phase)
      PhStart1, PhStart2: begin
        r.sda_level = (tick_cnt < 3'd4);
        if (tick_cnt >= 3'd7) begin
          // The read address wraps at eight bits.
          if (seq_phase == PhStart1) go_send(PhSendDev, dev_q);
          else go_send(PhSendDevr, dev_q + 8'd1);
        end else begin
          tick_cnt = tick_cnt + 3'd1;
        end
      end
      PhSendDev, PhSendReg, PhSendDevr, PhSendData: begin
        if (seq_phase == PhSendData && bit_cnt == '0 && tick_cnt == '0) begin
          shift_q    = rq.wr_byte;
          r.wr_taken = 1'b1;
        end
        r.sda_level = shift_q[7];
        r.scl_level = (tick_cnt == 3'd1);
        if (tick_cnt >= 3'd2) begin
          tick_cnt = '0;
          shift_q  = shift_q << 1;
          bit_cnt  = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            case (seq_phase)
              PhSendDev:  nxt = PhAckDev;
              PhSendReg:  nxt = PhAckReg;
              PhSendDevr: nxt = PhAckDevr;
              default:    nxt = PhAckData;
            endcase
            go_plain(nxt);
          end
        end else begin
          tick_cnt = tick_cnt + 3'd1;
        end
      end
      PhAckDev, PhAckReg, PhAckDevr, PhAckData: begin
        r.sda_drive_en = 1'b0;
        if (tick_cnt == 3'd0) begin
          r.scl_level = 1'b0;
          tick_cnt    = 3'd1;
        end else if (tick_cnt == 3'd1) begin
          tick_cnt = 3'd2;
        end else if (!rq.sda_in) begin
          case (seq_phase)
            PhAckDev: go_send(PhSendReg, reg_q);
            PhAckReg: begin
              bytes_moved = '0;
              if (read_mode) go_plain(PhStart2);
              else go_plain(count_q != '0 ? PhSendData : PhStop);
            end
            PhAckDevr: begin
              bytes_moved = '0;
              shift_q     = '0;
              go_plain(count_q != '0 ? PhReadBits : PhStop);
            end
            default: begin
              bytes_moved = bytes_moved + 8'd1;
              go_plain(bytes_moved < count_q ? PhSendData : PhStop);
            end
          endcase
        end else if (poll_cnt >= ack_limit) begin
          go_plain(PhStopFail);
        end else begin
          poll_cnt = poll_cnt + 8'd1;
        end
      end
      PhReadBits: begin
        r.sda_drive_en = 1'b0;
        if (tick_cnt == 3'd0) begin
          r.scl_level = 1'b0;
          tick_cnt    = 3'd1;
        end else begin
          shift_q  = {shift_q[6:0], rq.sda_in};
          tick_cnt = '0;
          bit_cnt  = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            seq_phase = PhMasterAck;
            bit_cnt   = '0;
          end
        end
      end
      PhMasterAck: begin
        // NACK the last byte, ACK every other one.
        last_byte   = ({1'b0, bytes_moved} + 9'd1) >= {1'b0, count_q};
        r.sda_level = last_byte;
        r.scl_level = (tick_cnt != 3'd0);
        if (tick_cnt >= (last_byte ? 3'd1 : 3'd2)) begin
          r.rd_byte   = shift_q;
          r.rd_valid  = 1'b1;
          bytes_moved = bytes_moved + 8'd1;
          shift_q     = '0;
          go_plain(bytes_moved >= count_q ? PhStop : PhReadBits);
        end else begin
          tick_cnt = tick_cnt + 3'd1;
        end
      end
      PhStop, PhStopFail: begin
        r.scl_level = (tick_cnt >= 3'd4);
        r.sda_level = r.scl_level;
        if (tick_cnt >= 3'd7) begin
          r.done_res  = 1'b1;
          r.failed    = (seq_phase == PhStopFail);
          go_plain(PhIdle);
          bytes_moved = '0;
        end else begin
          tick_cnt = tick_cnt + 3'd1;
        end
      end
      default: begin
        seq_phase  = PhIdle;
        tick_cnt   = '0;
        bit_cnt    = '0;
        r.busy_res = 1'b0;
      end
    endcase
    return r;
  endfunction

  // Build a tick with random payload. SDA answers ACK polls on purpose: low
  // with the chosen odds, always high while polling the refused ACK phase.
  function automatic req_t make_tick(input logic [ReqW-1:0] kind);
    req_t rq;
    rq.req_type   = kind;
    rq.dev_addr   = ByteW'($urandom_range(255));
    rq.reg_addr   = ByteW'($urandom_range(255));
    rq.byte_count = ByteW'($urandom_range(255));
    rq.wr_byte    = ByteW'($urandom_range(255));
    if (seq_phase inside {PhAckDev, PhAckReg, PhAckDevr, PhAckData} && tick_cnt >= 3'd2) begin
      if (seq_phase == refused_ack) rq.sda_in = 1'b1;
      else rq.sda_in = ($urandom_range(99) >= ack_pct);
    end else begin
      rq.sda_in = 1'($urandom_range(1));
    end
    return rq;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: stall at random, check every accepted result in order.
  // --------------------------------------------------------------------------
  initial begin
    res_if.ready = 1'b1;
    forever begin
      @(negedge clk_i);
      res_if.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
    if (exp !== act) begin
      err_cnt++;
      // Keep the log readable when a bug repeats on every tick.
      if (err_cnt <= PrintLimit)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
    end
  endtask

  initial begin
    res_t exp;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid === 1'b1 && res_if.ready) begin
        if (tick_levels_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result with no request pending, expected none, actual scl %0b sda %0b",
                   $time, res_if.scl_level, res_if.sda_level);
        end else begin
          exp = tick_levels_q.pop_front();
          check_field("scl_level", exp.scl_level, res_if.scl_level);
          check_field("sda_level", exp.sda_level, res_if.sda_level);
          check_field("sda_drive_en", exp.sda_drive_en, res_if.sda_drive_en);
          check_field("rd_byte", exp.rd_byte, res_if.rd_byte);
          check_field("rd_valid", exp.rd_valid, res_if.rd_valid);
          check_field("wr_taken", exp.wr_taken, res_if.wr_taken);
          check_field("busy_res", exp.busy_res, res_if.busy_res);
          check_field("done_res", exp.done_res, res_if.done_res);
          check_field("failed", exp.failed, res_if.failed);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Hold one request until accepted, idling first at random. Valid stays high
  // afterwards so back-to-back requests flow; callers that pause drop it.
  task automatic send_tick(input req_t rq);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      req_if.valid = 1'b0;
    end
    @(negedge clk_i);
    req_if.valid      = 1'b1;
    req_if.req_type   = rq.req_type;
    req_if.dev_addr   = rq.dev_addr;
    req_if.reg_addr   = rq.reg_addr;
    req_if.byte_count = rq.byte_count;
    req_if.wr_byte    = rq.wr_byte;
    req_if.sda_in     = rq.sda_in;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    tick_levels_q.push_back(predict_bus_tick(rq));
    items_sent++;
  endtask

  // Drop valid and hold until every predicted result has come back, followed
  // by an extra wait that covers the two-stage pipeline.
  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (tick_levels_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write, then read back: setup cycle, then access cycle until pready.
  // Only call idle.
  task automatic write_ack_timeout(input logic [ByteW-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = AckTimeoutAddr;
    pwdata  = ApbW'(value);
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    ack_limit = value;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== ApbW'(value)) begin
      err_cnt++;
      $display("%0t: ack_timeout readback mismatch, expected %0h, actual %0h",
               $time, value, prdata);
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Start a transfer and keep ticking until the model is idle again. Ticks
  // sent while busy carry random commands, which the block must ignore.
  task automatic run_transfer(input logic rd, input logic [ByteW-1:0] dev,
                              input logic [ByteW-1:0] rg, input logic [ByteW-1:0] cnt);
    req_t rq;
    rq            = make_tick(rd ? ReqRead : ReqWrite);
    rq.dev_addr   = dev;
    rq.reg_addr   = rg;
    rq.byte_count = cnt;
    send_tick(rq);
    while (seq_phase != PhIdle) begin
      rq = make_tick(ReqW'($urandom_range(3)));
      send_tick(rq);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_idle_ticks();
    req_t rq;
    for (int i = 0; i < 4; i++) begin
      rq        = make_tick(i[0] ? ReqIgnored : ReqTick);
      rq.sda_in = i[1];
      send_tick(rq);
    end
  endtask

  task automatic test_write_no_data();
    ack_pct = 100;
    run_transfer(1'b0, 8'h00, 8'hFF, 8'd0);
  endtask

  // Three bytes read at the wrapping address (two ACKs, then the NACK), then a zero-byte read.
  task automatic test_read_address_wrap();
    ack_pct = 100;
    run_transfer(1'b1, 8'hFF, 8'h00, 8'd3);
    run_transfer(1'b1, 8'h5A, 8'hA5, 8'd0);
  endtask

  task automatic test_write_data();
    ack_pct = 60;
    run_transfer(1'b0, 8'h5B, 8'hC3, 8'd3);
  endtask

  // Refuse each ACK phase in turn, with the shortest limit and a short nonzero one.
  task automatic test_ack_timeouts();
    wait_drained();
    write_ack_timeout(8'd0);
    refused_ack = PhAckDev;
    run_transfer(1'b0, 8'h12, 8'h34, 8'd2);
    refused_ack = PhAckReg;
    run_transfer(1'b1, 8'h12, 8'h34, 8'd2);
    refused_ack = PhAckDevr;
    run_transfer(1'b1, 8'h90, 8'h01, 8'd1);
    wait_drained();
    write_ack_timeout(8'd7);
    refused_ack = PhAckData;
    run_transfer(1'b0, 8'hEE, 8'h77, 8'd1);
    refused_ack = PhIdle;
    wait_drained();
    write_ack_timeout(AckTimeoutReset);
  endtask

  // Mostly well-formed transfers with small byte counts, a few long ones,
  // idle ticks and silent slaves in between.
  task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
                                     input logic [ByteW-1:0] limit, input int unsigned n);
    int unsigned first;
    int unsigned pick;
    logic [ByteW-1:0] cnt;
    wait_drained();
    gap_pct   = gap;
    stall_pct = stall;
    write_ack_timeout(limit);
    first = items_sent;
    while (items_sent - first < n) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        repeat ($urandom_range(5, 1))
          send_tick(make_tick($urandom_range(1) ? ReqTick : ReqIgnored));
      end else begin
        pick = $urandom_range(99);
        if (pick < 70) cnt = ByteW'($urandom_range(2));
        else if (pick < 95) cnt = ByteW'($urandom_range(6, 3));
        else cnt = ByteW'($urandom_range(40));
        ack_pct = ($urandom_range(99) < 80) ? 90 : 20;
        run_transfer(1'($urandom_range(1)), ByteW'($urandom_range(255)),
                     ByteW'($urandom_range(255)), cnt);
        // Now and then let the pipeline run dry before the next request.
        if ($urandom_range(9) == 0) wait_drained();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_if.valid      = 1'b0;
    req_if.req_type   = ReqTick;
    req_if.dev_addr   = '0;
    req_if.reg_addr   = '0;
    req_if.byte_count = '0;
    req_if.wr_byte    = '0;
    req_if.sda_in     = 1'b1;
    gap_pct           = 0;
    stall_pct         = 0;
    ack_pct           = 100;
    refused_ack       = PhIdle;
    items_sent        = 0;
    err_cnt           = 0;
    cycle_cnt         = 0;

    // Model reset state matches the block after rst_ni.
    seq_phase   = PhIdle;
    tick_cnt    = '0;
    bit_cnt     = '0;
    bytes_moved = '0;
    shift_q     = '0;
    poll_cnt    = '0;
    dev_q       = '0;
    reg_q       = '0;
    count_q     = '0;
    read_mode   = 1'b0;
    ack_limit   = AckTimeoutReset;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // No idling on either side.
    test_idle_ticks();
    test_write_no_data();
    test_read_address_wrap();

    // Sender idles most cycles.
    gap_pct = 65;
    test_write_data();

    // Receiver stalls most cycles.
    gap_pct   = 0;
    stall_pct = 65;
    test_ack_timeouts();

    // Light idling on both sides.
    test_random_traffic(12, 12, ByteW'($urandom_range(40, 2)), 40);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_req_if.sv
rtl/core/i2cm_res_if.sv
rtl/core/i2c_master_register_transfer.sv
tb/i2c_master_register_transfer_test.sv
